// ===== sv/mss_pkg.sv =====
// Package with shared types, codes and defaults of the motor start/stop supervisor.
`timescale 1ns / 1ps

package mss_pkg;

  // Default field widths.
  localparam int CURRENT_BITS_DEF = 12;
  localparam int TIME_BITS_DEF    = 32;

  // The spin-down delay register has a fixed width.
  localparam int              DELAY_BITS    = 16;
  localparam logic [DELAY_BITS-1:0] SPIN_DOWN_DEF = 16'd60000;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SYNC_U    = 3'd0,
    CFG_SYNC_V    = 3'd1,
    CFG_SYNC_W    = 3'd2,
    CFG_MARGIN    = 3'd3,
    CFG_DOWN_DLY  = 3'd4
  } cfg_idx_t;

  // Mode codes as reported on the result channel.
  localparam int MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_INITIAL = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_IDLE    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_UP      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_READY   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_DOWN    = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_ERROR   = 3'd5;

  // Supervisor states, one-hot.
  typedef enum logic [5:0] {
    ST_POWER_ON = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_UP       = 6'b000100,
    ST_READY    = 6'b001000,
    ST_DOWN     = 6'b010000,
    ST_FAULTED  = 6'b100000
  } state_t;

  // Map a state to its reported mode code.
  function automatic logic [MODE_BITS-1:0] mode_of(state_t st);
    logic [MODE_BITS-1:0] m;
    case (st)
      ST_POWER_ON: m = MODE_INITIAL;
      ST_IDLE:     m = MODE_IDLE;
      ST_UP:       m = MODE_UP;
      ST_READY:    m = MODE_READY;
      ST_DOWN:     m = MODE_DOWN;
      ST_FAULTED:  m = MODE_ERROR;
      default:     m = MODE_INITIAL;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/mss_if.sv =====
// Valid/ready channel interfaces for supervision steps and their results.
`timescale 1ns / 1ps

interface mss_in_if #(
  parameter int CURRENT_BITS = mss_pkg::CURRENT_BITS_DEF,
  parameter int TIME_BITS    = mss_pkg::TIME_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [TIME_BITS-1:0]    now_ms;
  logic [CURRENT_BITS-1:0] phase_u_current;
  logic [CURRENT_BITS-1:0] phase_v_current;
  logic [CURRENT_BITS-1:0] phase_w_current;
  logic                    start_pulse;
  logic                    stop_pulse;
  logic                    ack_pulse;
  logic                    fault;

  modport source (
    output valid, now_ms, phase_u_current, phase_v_current, phase_w_current,
           start_pulse, stop_pulse, ack_pulse, fault,
    input  ready
  );
  modport sink (
    input  valid, now_ms, phase_u_current, phase_v_current, phase_w_current,
           start_pulse, stop_pulse, ack_pulse, fault,
    output ready
  );
endinterface

interface mss_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       pwm_start;
  logic       halt_motor;
  logic       moved;

  modport source (output valid, mode, pwm_start, halt_motor, moved, input ready);
  modport sink (input valid, mode, pwm_start, halt_motor, moved, output ready);
endinterface

// ===== sv/mss_cfg_regs.sv =====
// Configuration register file: phase current targets, margin and spin-down delay.
`timescale 1ns / 1ps

module mss_cfg_regs #(
  parameter int CURRENT_BITS = mss_pkg::CURRENT_BITS_DEF,
  parameter int CFG_BITS     = mss_pkg::DELAY_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mss_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_BITS-1:0]               cfg_data,
  output logic [CURRENT_BITS-1:0]           sync_u,
  output logic [CURRENT_BITS-1:0]           sync_v,
  output logic [CURRENT_BITS-1:0]           sync_w,
  output logic [CURRENT_BITS-1:0]           margin,
  output logic [mss_pkg::DELAY_BITS-1:0]    down_dly
);
  import mss_pkg::*;

  logic [CURRENT_BITS-1:0] sync_u_r, sync_v_r, sync_w_r, margin_r;
  logic [DELAY_BITS-1:0]   down_dly_r;

  // Writes land on the addressed register; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_u_r   <= '0;
      sync_v_r   <= '0;
      sync_w_r   <= '0;
      margin_r   <= '0;
      down_dly_r <= SPIN_DOWN_DEF;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_SYNC_U:   sync_u_r   <= cfg_data[CURRENT_BITS-1:0];
        CFG_SYNC_V:   sync_v_r   <= cfg_data[CURRENT_BITS-1:0];
        CFG_SYNC_W:   sync_w_r   <= cfg_data[CURRENT_BITS-1:0];
        CFG_MARGIN:   margin_r   <= cfg_data[CURRENT_BITS-1:0];
        CFG_DOWN_DLY: down_dly_r <= cfg_data[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign sync_u   = sync_u_r;
  assign sync_v   = sync_v_r;
  assign sync_w   = sync_w_r;
  assign margin   = margin_r;
  assign down_dly = down_dly_r;

endmodule

// ===== sv/mss_in_stage.sv =====
// Input register that holds one supervision step until the core takes it.
`timescale 1ns / 1ps

module mss_in_stage #(
  parameter int CURRENT_BITS = mss_pkg::CURRENT_BITS_DEF,
  parameter int TIME_BITS    = mss_pkg::TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  mss_in_if.sink                  in_req,
  input  logic                    s1_take,
  output logic                    s1_valid,
  output logic [TIME_BITS-1:0]    s1_now,
  output logic [CURRENT_BITS-1:0] s1_iu,
  output logic [CURRENT_BITS-1:0] s1_iv,
  output logic [CURRENT_BITS-1:0] s1_iw,
  output logic                    s1_start,
  output logic                    s1_stop,
  output logic                    s1_ack,
  output logic                    s1_fault
);
  logic                    valid_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [CURRENT_BITS-1:0] iu_r, iv_r, iw_r;
  logic                    start_r, stop_r, ack_r, fault_r;
  logic                    load;

  // The stage refills in the same cycle that the core empties it.
  assign in_req.ready = !valid_r || s1_take;
  assign load         = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_req.ready) begin
      valid_r <= in_req.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      now_r   <= in_req.now_ms;
      iu_r    <= in_req.phase_u_current;
      iv_r    <= in_req.phase_v_current;
      iw_r    <= in_req.phase_w_current;
      start_r <= in_req.start_pulse;
      stop_r  <= in_req.stop_pulse;
      ack_r   <= in_req.ack_pulse;
      fault_r <= in_req.fault;
    end
  end

  assign s1_valid = valid_r;
  assign s1_now   = now_r;
  assign s1_iu    = iu_r;
  assign s1_iv    = iv_r;
  assign s1_iw    = iw_r;
  assign s1_start = start_r;
  assign s1_stop  = stop_r;
  assign s1_ack   = ack_r;
  assign s1_fault = fault_r;

endmodule

// ===== sv/mss_core.sv =====
// Supervisor state machine: flags, entry actions, transitions and result register.
`timescale 1ns / 1ps

module mss_core #(
  parameter int CURRENT_BITS = mss_pkg::CURRENT_BITS_DEF,
  parameter int TIME_BITS    = mss_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  input  logic [TIME_BITS-1:0]           s1_now,
  input  logic [CURRENT_BITS-1:0]        s1_iu,
  input  logic [CURRENT_BITS-1:0]        s1_iv,
  input  logic [CURRENT_BITS-1:0]        s1_iw,
  input  logic                           s1_start,
  input  logic                           s1_stop,
  input  logic                           s1_ack,
  input  logic                           s1_fault,
  output logic                           s1_take,
  input  logic [CURRENT_BITS-1:0]        sync_u,
  input  logic [CURRENT_BITS-1:0]        sync_v,
  input  logic [CURRENT_BITS-1:0]        sync_w,
  input  logic [CURRENT_BITS-1:0]        margin,
  input  logic [mss_pkg::DELAY_BITS-1:0] down_dly,
  mss_out_if.source                      out_res
);
  import mss_pkg::*;

  // Supervisor state.
  state_t               state_r, state_nxt;
  logic                 entry_r, entry_nxt;
  logic                 start_f_r, start_f_nxt;
  logic                 stop_f_r, stop_f_nxt;
  logic                 ack_f_r, ack_f_nxt;
  logic [TIME_BITS-1:0] sds_r, sds_nxt;

  // Result register.
  logic                 out_valid_r;
  logic [MODE_BITS-1:0] mode_r;
  logic                 run_r, run_nxt;
  logic                 halt_r, halt_nxt;
  logic                 moved_r, moved_nxt;

  logic [CURRENT_BITS-1:0] du, dv, dw;
  logic                    in_margin;
  logic [TIME_BITS-1:0]    elapsed;
  logic                    motor_down;

  assign s1_take = s1_valid && (!out_valid_r || out_res.ready);

  // Absolute deviations of the three phase currents from their targets.
  assign du = (s1_iu >= sync_u) ? s1_iu - sync_u : sync_u - s1_iu;
  assign dv = (s1_iv >= sync_v) ? s1_iv - sync_v : sync_v - s1_iv;
  assign dw = (s1_iw >= sync_w) ? s1_iw - sync_w : sync_w - s1_iw;
  assign in_margin = (du <= margin) && (dv <= margin) && (dw <= margin);

  // Wrapping elapsed time since stop; it is zero on the step of entry.
  assign elapsed    = (entry_r && state_r == ST_DOWN) ? '0 : s1_now - sds_r;
  assign motor_down = elapsed >= TIME_BITS'(down_dly);

  // One supervision step: pulses, entry action, then prioritized transitions.
  always_comb begin
    start_f_nxt = start_f_r | s1_start;
    stop_f_nxt  = stop_f_r | s1_stop;
    ack_f_nxt   = ack_f_r | s1_ack;
    sds_nxt     = sds_r;
    run_nxt     = 1'b0;
    halt_nxt    = 1'b0;
    state_nxt   = state_r;
    moved_nxt   = 1'b0;

    if (entry_r) begin
      case (state_r)
        ST_IDLE: begin
          start_f_nxt = 1'b0;
          stop_f_nxt  = 1'b0;
          ack_f_nxt   = 1'b0;
        end
        ST_UP: begin
          run_nxt = 1'b1;
        end
        ST_DOWN: begin
          halt_nxt = 1'b1;
          sds_nxt  = s1_now;
        end
        default: ;
      endcase
    end

    case (state_r)
      ST_POWER_ON: begin
        state_nxt = ST_IDLE;
        moved_nxt = 1'b1;
      end
      ST_IDLE: begin
        if (start_f_nxt) begin
          start_f_nxt = 1'b0;
          state_nxt   = ST_UP;
          moved_nxt   = 1'b1;
        end
      end
      ST_UP: begin
        if (s1_fault) begin
          state_nxt = ST_FAULTED;
          moved_nxt = 1'b1;
        end else if (stop_f_nxt) begin
          stop_f_nxt = 1'b0;
          state_nxt  = ST_DOWN;
          moved_nxt  = 1'b1;
        end else if (in_margin) begin
          state_nxt = ST_READY;
          moved_nxt = 1'b1;
        end
      end
      ST_READY: begin
        if (s1_fault) begin
          state_nxt = ST_FAULTED;
          moved_nxt = 1'b1;
        end else if (stop_f_nxt) begin
          stop_f_nxt = 1'b0;
          state_nxt  = ST_DOWN;
          moved_nxt  = 1'b1;
        end
      end
      ST_DOWN: begin
        if (s1_fault) begin
          state_nxt = ST_FAULTED;
          moved_nxt = 1'b1;
        end else if (motor_down) begin
          state_nxt = ST_IDLE;
          moved_nxt = 1'b1;
        end else if (start_f_nxt) begin
          start_f_nxt = 1'b0;
          state_nxt   = ST_UP;
          moved_nxt   = 1'b1;
        end
      end
      ST_FAULTED: begin
        // Error re-enters itself until an acknowledge is seen.
        if (ack_f_nxt) begin
          ack_f_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
        moved_nxt = 1'b1;
      end
      default: ;
    endcase

    entry_nxt = moved_nxt;
  end

  // State advances only when a step is taken from the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_POWER_ON;
      entry_r   <= 1'b1;
      start_f_r <= 1'b0;
      stop_f_r  <= 1'b0;
      ack_f_r   <= 1'b0;
      sds_r     <= '0;
    end else if (s1_take) begin
      state_r   <= state_nxt;
      entry_r   <= entry_nxt;
      start_f_r <= start_f_nxt;
      stop_f_r  <= stop_f_nxt;
      ack_f_r   <= ack_f_nxt;
      sds_r     <= sds_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      mode_r  <= mode_of(state_nxt);
      run_r   <= run_nxt;
      halt_r  <= halt_nxt;
      moved_r <= moved_nxt;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.mode       = mode_r;
  assign out_res.pwm_start  = run_r;
  assign out_res.halt_motor = halt_r;
  assign out_res.moved      = moved_r;

endmodule

// ===== sv/motor_start_stop_supervisor.sv =====
// Top level of the motor start/stop supervisor.
//
//  Channel  Direction  Handshake        Carries
//  in_req   in         valid / ready    now_ms, three phase currents, pulses, fault
//  out_res  out        valid / ready    mode, pwm_start, halt_motor, moved
//  cfg_*    in         write enable     register index and data, no read-back
//
// One request is accepted per cycle while input ready is high; its result is registered.
// The state machine and result register update together when a step is taken from the input register.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A stalled result holds its register and the input register, and input
// ready drops only while both are full.
`timescale 1ns / 1ps

module motor_start_stop_supervisor #(
  parameter int CURRENT_BITS = mss_pkg::CURRENT_BITS_DEF,
  parameter int TIME_BITS    = mss_pkg::TIME_BITS_DEF,
  parameter int CFG_BITS     = (CURRENT_BITS > mss_pkg::DELAY_BITS) ?
                               CURRENT_BITS : mss_pkg::DELAY_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mss_in_if.sink                           in_req,
  mss_out_if.source                        out_res,
  input  logic                             cfg_we,
  input  logic [mss_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [CFG_BITS-1:0]              cfg_data
);
  import mss_pkg::*;

  logic [CURRENT_BITS-1:0] sync_u, sync_v, sync_w, margin;
  logic [DELAY_BITS-1:0]   down_dly;

  logic                    s1_valid, s1_take;
  logic [TIME_BITS-1:0]    s1_now;
  logic [CURRENT_BITS-1:0] s1_iu, s1_iv, s1_iw;
  logic                    s1_start, s1_stop, s1_ack, s1_fault;

  mss_cfg_regs #(
    .CURRENT_BITS (CURRENT_BITS),
    .CFG_BITS     (CFG_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .sync_u   (sync_u),
    .sync_v   (sync_v),
    .sync_w   (sync_w),
    .margin   (margin),
    .down_dly (down_dly)
  );

  mss_in_stage #(
    .CURRENT_BITS (CURRENT_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_now   (s1_now),
    .s1_iu    (s1_iu),
    .s1_iv    (s1_iv),
    .s1_iw    (s1_iw),
    .s1_start (s1_start),
    .s1_stop  (s1_stop),
    .s1_ack   (s1_ack),
    .s1_fault (s1_fault)
  );

  mss_core #(
    .CURRENT_BITS (CURRENT_BITS),
    .TIME_BITS    (TIME_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_now   (s1_now),
    .s1_iu    (s1_iu),
    .s1_iv    (s1_iv),
    .s1_iw    (s1_iw),
    .s1_start (s1_start),
    .s1_stop  (s1_stop),
    .s1_ack   (s1_ack),
    .s1_fault (s1_fault),
    .s1_take  (s1_take),
    .sync_u   (sync_u),
    .sync_v   (sync_v),
    .sync_w   (sync_w),
    .margin   (margin),
    .down_dly (down_dly),
    .out_res  (out_res)
  );

endmodule

// ===== sv/mss_checker.sv =====
// Port-level checks on the supervisor's result channel, bound to the top level.
`timescale 1ns / 1ps

module mss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_mode,
  input logic       out_run,
  input logic       out_halt,
  input logic       out_moved
);
  import mss_pkg::*;

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_mode, out_run, out_halt, out_moved}))
    else $error("result payload changed while stalled");

  // The initial state is always left on the first step, and no unused code shows.
  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mode != MODE_INITIAL) && (out_mode <= MODE_ERROR))
    else $error("result mode is initial or unused");

  // Speeding up and speeding down cannot both be entered in one step.
  a_run_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_run && out_halt))
    else $error("run and halt reported together");

  // Residence in error always counts as a transition.
  a_error_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_moved |-> out_mode != MODE_ERROR)
    else $error("error mode reported without a transition");

endmodule

bind motor_start_stop_supervisor mss_checker u_mss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_mode  (out_res.mode),
  .out_run   (out_res.pwm_start),
  .out_halt  (out_res.halt_motor),
  .out_moved (out_res.moved)
);

// ===== verif/tb_motor_start_stop_supervisor.sv =====
// Self-checking testbench for the motor start/stop supervisor.
`timescale 1ns / 1ps

module tb_motor_start_stop_supervisor;
  import mss_pkg::*;

  localparam int CB = CURRENT_BITS_DEF;
  localparam int TB = TIME_BITS_DEF;
  localparam int CFG_W = (CB > DELAY_BITS) ? CB : DELAY_BITS;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  // One supervision step request and the result it causes.
  typedef struct packed {
    logic [TB-1:0] now_ms;
    logic [CB-1:0] phase_u_current;
    logic [CB-1:0] phase_v_current;
    logic [CB-1:0] phase_w_current;
    logic          start_pulse;
    logic          stop_pulse;
    logic          ack_pulse;
    logic          fault;
  } step_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 pwm_start;
    logic                 halt_motor;
    logic                 moved;
  } sup_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = CFG_SYNC_U;
  logic [CFG_W-1:0] cfg_data = '0;

  mss_in_if in_ch ();
  mss_out_if out_ch ();

  motor_start_stop_supervisor u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the configuration registers.
  logic [CB-1:0]         tgt_u = '0;
  logic [CB-1:0]         tgt_v = '0;
  logic [CB-1:0]         tgt_w = '0;
  logic [CB-1:0]         margin = '0;
  logic [DELAY_BITS-1:0] down_delay = SPIN_DOWN_DEF;

  // Predictor copy of the supervisor state.
  logic [MODE_BITS-1:0] sv_mode = MODE_INITIAL;
  logic                 entry_due = 1'b1;
  logic                 start_f = 1'b0;
  logic                 stop_f = 1'b0;
  logic                 ack_f = 1'b0;
  logic [TB-1:0]        down_t0 = '0;

  sup_result_t pending_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  logic hold_active = 1'b0;
  logic [TB-1:0] clock_ms = '0;
  event hold_go;

  // Absolute deviation of a sample from its target, without wrap.
  function automatic logic in_margin(logic [CB-1:0] sample, logic [CB-1:0] target,
                                     logic [CB-1:0] limit);
    int d;
    d = int'(sample) - int'(target);
    if (d < 0) d = -d;
    return d <= int'(limit);
  endfunction

  // One supervision step: flags, entry action, prioritized transitions.
  function automatic sup_result_t supervise_step(step_t s);
    sup_result_t r;
    logic [MODE_BITS-1:0] nxt;
    logic taken;
    logic [TB-1:0] elapsed;
    r = '0;
    nxt = sv_mode;
    taken = 1'b0;
    if (s.start_pulse) start_f = 1'b1;
    if (s.stop_pulse) stop_f = 1'b1;
    if (s.ack_pulse) ack_f = 1'b1;
    if (entry_due) begin
      case (sv_mode)
        MODE_IDLE: begin
          start_f = 1'b0;
          stop_f = 1'b0;
          ack_f = 1'b0;
        end
        MODE_UP: r.pwm_start = 1'b1;
        MODE_DOWN: begin
          r.halt_motor = 1'b1;
          down_t0 = s.now_ms;
        end
        default: ;
      endcase
    end
    case (sv_mode)
      MODE_INITIAL: begin
        nxt = MODE_IDLE;
        taken = 1'b1;
      end
      MODE_IDLE: begin
        if (start_f) begin
          start_f = 1'b0;
          nxt = MODE_UP;
          taken = 1'b1;
        end
      end
      MODE_UP: begin
        if (s.fault) begin
          nxt = MODE_ERROR;
          taken = 1'b1;
        end else if (stop_f) begin
          stop_f = 1'b0;
          nxt = MODE_DOWN;
          taken = 1'b1;
        end else if (in_margin(s.phase_u_current, tgt_u, margin) &&
                     in_margin(s.phase_v_current, tgt_v, margin) &&
                     in_margin(s.phase_w_current, tgt_w, margin)) begin
          nxt = MODE_READY;
          taken = 1'b1;
        end
      end
      MODE_READY: begin
        if (s.fault) begin
          nxt = MODE_ERROR;
          taken = 1'b1;
        end else if (stop_f) begin
          stop_f = 1'b0;
          nxt = MODE_DOWN;
          taken = 1'b1;
        end
      end
      MODE_DOWN: begin
        elapsed = s.now_ms - down_t0;
        if (s.fault) begin
          nxt = MODE_ERROR;
          taken = 1'b1;
        end else if (elapsed >= TB'(down_delay)) begin
          nxt = MODE_IDLE;
          taken = 1'b1;
        end else if (start_f) begin
          start_f = 1'b0;
          nxt = MODE_UP;
          taken = 1'b1;
        end
      end
      MODE_ERROR: begin
        if (ack_f) begin
          ack_f = 1'b0;
          nxt = MODE_IDLE;
        end else begin
          nxt = MODE_ERROR;
        end
        taken = 1'b1;
      end
      default: ;
    endcase
    entry_due = taken;
    sv_mode = nxt;
    r.mode = nxt;
    r.moved = taken;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 40)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Output ready, random stalls plus the long hold-off.
  always @(posedge clk) begin
    out_ch.ready <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here in cycles.
  always begin
    @(hold_go);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Predict on each accepted request and check each accepted result.
  always @(posedge clk) begin
    sup_result_t want;
    step_t s;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", int'(out_ch.mode), -1);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.mode !== want.mode)
            report_mismatch("mode", int'(out_ch.mode), int'(want.mode));
          if (out_ch.pwm_start !== want.pwm_start)
            report_mismatch("pwm_start", int'(out_ch.pwm_start), int'(want.pwm_start));
          if (out_ch.halt_motor !== want.halt_motor)
            report_mismatch("halt_motor", int'(out_ch.halt_motor), int'(want.halt_motor));
          if (out_ch.moved !== want.moved)
            report_mismatch("moved", int'(out_ch.moved), int'(want.moved));
          checked_count++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        s.now_ms = in_ch.now_ms;
        s.phase_u_current = in_ch.phase_u_current;
        s.phase_v_current = in_ch.phase_v_current;
        s.phase_w_current = in_ch.phase_w_current;
        s.start_pulse = in_ch.start_pulse;
        s.stop_pulse = in_ch.stop_pulse;
        s.ack_pulse = in_ch.ack_pulse;
        s.fault = in_ch.fault;
        pending_results.push_back(supervise_step(s));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("** motor_start_stop_supervisor: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, with random idle cycles ahead of it, until accepted.
  task automatic send_step(input step_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.now_ms <= s.now_ms;
    in_ch.phase_u_current <= s.phase_u_current;
    in_ch.phase_v_current <= s.phase_v_current;
    in_ch.phase_w_current <= s.phase_w_current;
    in_ch.start_pulse <= s.start_pulse;
    in_ch.stop_pulse <= s.stop_pulse;
    in_ch.ack_pulse <= s.ack_pulse;
    in_ch.fault <= s.fault;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  function automatic step_t mk_step(logic [TB-1:0] now, logic [CB-1:0] iu,
                                    logic [CB-1:0] iv, logic [CB-1:0] iw,
                                    logic st, logic sp, logic ak, logic flt);
    step_t s;
    s.now_ms = now;
    s.phase_u_current = iu;
    s.phase_v_current = iv;
    s.phase_w_current = iw;
    s.start_pulse = st;
    s.stop_pulse = sp;
    s.ack_pulse = ak;
    s.fault = flt;
    return s;
  endfunction

  // Stop offering and wait until every expected result has been checked.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five registers on consecutive cycles while the block is idle.
  task automatic load_settings(int u, int v, int w, int m, int d);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SYNC_U;
    cfg_data <= CFG_W'(u);
    @(posedge clk);
    cfg_idx <= CFG_SYNC_V;
    cfg_data <= CFG_W'(v);
    @(posedge clk);
    cfg_idx <= CFG_SYNC_W;
    cfg_data <= CFG_W'(w);
    @(posedge clk);
    cfg_idx <= CFG_MARGIN;
    cfg_data <= CFG_W'(m);
    @(posedge clk);
    cfg_idx <= CFG_DOWN_DLY;
    cfg_data <= CFG_W'(d);
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt_u = CB'(u);
    tgt_v = CB'(v);
    tgt_w = CB'(w);
    margin = CB'(m);
    down_delay = DELAY_BITS'(d);
  endtask

  // A current sample, mostly close to its target so the ready test fires.
  function automatic logic [CB-1:0] pick_current(logic [CB-1:0] target);
    int r;
    int c;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      c = int'(target) + $urandom_range(0, 2 * int'(margin) + 4) - int'(margin) - 2;
      if (c < 0) c = 0;
      if (c > (1 << CB) - 1) c = (1 << CB) - 1;
    end else if (r < 80) begin
      c = (r < 75) ? 0 : (1 << CB) - 1;
    end else begin
      c = $urandom_range(0, (1 << CB) - 1);
    end
    return CB'(c);
  endfunction

  // A random step on an advancing, wrapping millisecond clock.
  function automatic step_t random_step();
    int r;
    int inc;
    r = $urandom_range(0, 99);
    if (r < 80) inc = $urandom_range(0, 8);
    else if (r < 95) inc = $urandom_range(0, 400);
    else inc = $urandom_range(0, 140000);
    clock_ms = clock_ms + TB'(inc);
    return mk_step(clock_ms, pick_current(tgt_u), pick_current(tgt_v),
                   pick_current(tgt_w), $urandom_range(0, 99) < 12,
                   $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 25,
                   $urandom_range(0, 99) < 4);
  endfunction

  // Reset values: zero targets and margin, the long default spin-down delay.
  task automatic test_reset_defaults();
    send_step(mk_step(0, 0, 0, 0, 0, 0, 0, 0));
    // A start request on the step that runs the idle entry action is lost.
    send_step(mk_step(1, 0, 0, 0, 1, 0, 0, 0));
    send_step(mk_step(2, 0, 0, 0, 1, 0, 0, 0));
    send_step(mk_step(3, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(100, 0, 0, 0, 0, 1, 0, 0));
    send_step(mk_step(100, 4095, 4095, 4095, 0, 0, 0, 0));
    send_step(mk_step(60099, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(60100, 0, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Priorities, the margin boundary, the timestamp wrap and error residence.
  task automatic test_directed();
    load_settings(2000, 2000, 2000, 10, 5);
    send_step(mk_step(10, 0, 0, 0, 1, 1, 1, 0));
    send_step(mk_step(11, 0, 0, 0, 1, 0, 0, 0));
    send_step(mk_step(12, 4095, 0, 4095, 0, 0, 0, 0));
    send_step(mk_step(13, 2011, 2000, 2000, 0, 0, 0, 0));
    send_step(mk_step(14, 2010, 1990, 2000, 0, 1, 0, 0));
    send_step(mk_step(32'hFFFF_FFFE, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(32'h0000_0000, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(32'h0000_0003, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(4, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(5, 0, 0, 0, 1, 0, 0, 0));
    // Fault outranks stop while speeding up; error then re-enters itself.
    send_step(mk_step(6, 0, 0, 0, 0, 1, 0, 1));
    send_step(mk_step(7, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(8, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(9, 0, 0, 0, 0, 0, 1, 0));
    send_step(mk_step(20, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(21, 1990, 2010, 1990, 1, 0, 0, 0));
    send_step(mk_step(22, 1990, 2010, 1990, 0, 0, 0, 0));
    send_step(mk_step(23, 0, 0, 0, 0, 1, 0, 1));
    send_step(mk_step(24, 0, 0, 0, 0, 0, 1, 0));
    send_step(mk_step(25, 0, 0, 0, 0, 0, 0, 0));
    // Start before the delay has run out leaves speeding down for speeding up.
    send_step(mk_step(26, 0, 0, 0, 1, 0, 0, 0));
    send_step(mk_step(27, 0, 0, 0, 0, 1, 0, 0));
    send_step(mk_step(28, 0, 0, 0, 1, 0, 0, 0));
    send_step(mk_step(29, 0, 0, 0, 0, 1, 0, 0));
    send_step(mk_step(30, 0, 0, 0, 0, 0, 0, 1));
    send_step(mk_step(31, 0, 0, 0, 0, 0, 1, 0));
    drain();
    // A zero delay is met on the very step of entry; the widest margin always passes.
    load_settings(0, 0, 0, 4095, 0);
    send_step(mk_step(40, 0, 0, 0, 0, 0, 0, 0));
    send_step(mk_step(41, 0, 0, 0, 1, 0, 0, 0));
    send_step(mk_step(42, 4095, 4095, 4095, 0, 0, 0, 0));
    send_step(mk_step(43, 0, 0, 0, 0, 1, 0, 0));
    send_step(mk_step(44, 0, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Random steps under one register setting and one handshake mix.
  task automatic test_random_mix(int n, int idle_pct, int stall_pct,
                                 int u, int v, int w, int m, int d);
    load_settings(u, v, w, m, d);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    clock_ms = TB'($urandom);
    repeat (n) send_step(random_step());
    drain();
  endtask

  // The receiver holds off while requests keep coming, so the input stalls.
  task automatic test_output_hold();
    load_settings(1000, 3000, 2048, 50, 15);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> hold_go;
    repeat (40) send_step(random_step());
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.now_ms = '0;
    in_ch.phase_u_current = '0;
    in_ch.phase_v_current = '0;
    in_ch.phase_w_current = '0;
    in_ch.start_pulse = 1'b0;
    in_ch.stop_pulse = 1'b0;
    in_ch.ack_pulse = 1'b0;
    in_ch.fault = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_random_mix(370, 0, 0, 0, 0, 0, 4095, 0);
    test_random_mix(370, 64, 0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), 30, 20);
    test_random_mix(370, 0, 64, 4095, 4095, 4095, 0, 65535);
    test_random_mix(370, 12, 12, 2048, 100, 3900, 100, 300);
    test_output_hold();

    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    $display("Sent %0d steps, checked %0d results: reset defaults, directed cases,",
             sent_count, checked_count);
    $display("four handshake mixes over extreme settings and a long output hold-off.");
    if (mismatch_count == 0) begin
      $display("** motor_start_stop_supervisor: PASSED **");
    end else begin
      $display("** motor_start_stop_supervisor: FAILED **");
    end
    $finish;
  end

endmodule
